[hdl/msagg_pkg.sv]
`default_nettype none
package msagg_pkg;

	localparam int unsigned STAMP_W       = 32;
	localparam int unsigned SAMPLE_W      = 32;
	localparam int unsigned METHOD_W      = 2;
	localparam int unsigned REQ_W         = 5;
	localparam int unsigned CFG_DATA_W    = 5;
	localparam int unsigned CFG_INDEX_W   = 1;
	localparam int unsigned MAX_SOURCES_DEF = 16;
	localparam int unsigned QUEUE_DEPTH   = 2;

	localparam logic [METHOD_W-1:0] RED_AVG = 2'd0;
	localparam logic [METHOD_W-1:0] RED_MIN = 2'd1;
	localparam logic [METHOD_W-1:0] RED_MAX = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_METHOD   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_REQUIRED = 1'd1;

	localparam logic [REQ_W-1:0] REQ_RESET = 5'd1;

	typedef struct packed {
		logic [METHOD_W-1:0] method;
		logic [REQ_W-1:0]    required_count;
	} cfg_t;

endpackage
`default_nettype wire

[hdl/msagg_fifo.sv]
`default_nettype none
module msagg_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

[hdl/msagg_front.sv]
`default_nettype none
module msagg_front #(
	parameter int unsigned MAX_SOURCES = 16,
	parameter int unsigned CNT_W       = 5,
	parameter int unsigned SUM_W       = 37,
	parameter int unsigned REC_W       = 108
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire msagg_pkg::cfg_t                   cfg,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [msagg_pkg::STAMP_W-1:0]     stamp,
	input  wire logic signed [msagg_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                              usable,
	input  wire logic                              last_source,
	input  wire logic                              fifo_full,
	output logic                                   push,
	output logic [REC_W-1:0]                       rec
);
	import msagg_pkg::*;

	localparam int unsigned CMP_W = (CNT_W > REQ_W) ? CNT_W : REQ_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SOURCES);

	logic signed [SUM_W-1:0]    sum_q, sum_nx, sum_e;
	logic signed [SAMPLE_W-1:0] min_q, max_q, min_nx, max_nx, min_e, max_e;
	logic [CNT_W-1:0]           cnt_q, cnt_e;
	logic                       accept, take, first;
	logic [REQ_W-1:0]           need;
	logic                       quorum, is_min, is_max;
	logic signed [SAMPLE_W-1:0] value;

	assign in_stall = fifo_full;
	assign accept   = in_valid & ~fifo_full;
	assign take     = accept & usable & (cnt_q < MAX_CNT);
	assign first    = (cnt_q == '0);

	always_comb begin
		sum_nx = sum_q + SUM_W'(sample);
		min_nx = (first || sample < min_q) ? sample : min_q;
		max_nx = (first || sample > max_q) ? sample : max_q;
		sum_e  = take ? sum_nx : sum_q;
		min_e  = take ? min_nx : min_q;
		max_e  = take ? max_nx : max_q;
		cnt_e  = take ? cnt_q + 1'b1 : cnt_q;
	end

	// quorum and method are settled at the closing word
	always_comb begin
		need   = (cfg.required_count == '0) ? REQ_W'(1) : cfg.required_count;
		quorum = (cnt_e != '0) && (CMP_W'(cnt_e) >= CMP_W'(need));
		is_min = (cfg.method == RED_MIN);
		is_max = (cfg.method == RED_MAX);
		value  = '0;
		if (quorum && is_min) begin
			value = min_e;
		end else if (quorum && is_max) begin
			value = max_e;
		end
	end

	assign push = accept & last_source;
	assign rec  = {stamp, sum_e, cnt_e, value, quorum, quorum & ~is_min & ~is_max};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			min_q <= '0;
			max_q <= '0;
			cnt_q <= '0;
		end else if (push) begin
			sum_q <= '0;
			min_q <= '0;
			max_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			sum_q <= sum_nx;
			min_q <= min_nx;
			max_q <= max_nx;
			cnt_q <= cnt_e;
		end
	end
endmodule
`default_nettype wire

[hdl/msagg_back.sv]
`default_nettype none
module msagg_back #(
	parameter int unsigned CNT_W = 5,
	parameter int unsigned SUM_W = 37,
	parameter int unsigned REC_W = 108
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [REC_W-1:0]                  rec,
	input  wire logic                              fifo_empty,
	output logic                                   pop,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [msagg_pkg::STAMP_W-1:0]          out_stamp,
	output logic signed [msagg_pkg::SAMPLE_W-1:0]  aggregate,
	output logic                                   aggregate_valid
);
	import msagg_pkg::*;

	localparam int unsigned STEP_W = $clog2(SUM_W + 1);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [STAMP_W-1:0]         r_stamp;
	logic signed [SUM_W-1:0]    r_sum;
	logic [CNT_W-1:0]           r_cnt;
	logic signed [SAMPLE_W-1:0] r_value;
	logic                       r_valid, r_div;

	logic [1:0]           state_q;
	logic [STEP_W-1:0]    step_q;
	logic [SUM_W-1:0]     mag_q;
	logic [CNT_W-1:0]     rem_q, div_q;
	logic                 neg_q;
	logic [STAMP_W-1:0]   stamp_q;
	logic                 out_valid_q;
	logic [STAMP_W-1:0]   out_stamp_q;
	logic [SAMPLE_W-1:0]  aggregate_q;
	logic                 aggregate_valid_q;

	logic               out_free;
	logic [CNT_W:0]     rem_sh, rem_sub;
	logic               ge;
	logic [SAMPLE_W-1:0] quo;

	assign {r_stamp, r_sum, r_cnt, r_value, r_valid, r_div} = rec;

	assign out_free = ~out_valid_q | ~out_stall;
	assign pop      = (state_q == ST_IDLE) & ~fifo_empty & out_free;

	// restoring divide of the sum magnitude, one quotient bit per cycle
	assign rem_sh  = {rem_q, mag_q[SUM_W-1]};
	assign ge      = (rem_sh >= {1'b0, div_q});
	assign rem_sub = ge ? rem_sh - {1'b0, div_q} : rem_sh;
	assign quo     = mag_q[SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (pop && r_div) begin
			stamp_q <= r_stamp;
			neg_q   <= r_sum[SUM_W-1];
			mag_q   <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
			div_q   <= r_cnt;
			rem_q   <= '0;
		end else if (state_q == ST_DIV) begin
			mag_q <= {mag_q[SUM_W-2:0], ge};
			rem_q <= rem_sub[CNT_W-1:0];
		end
		if (pop && !r_div) begin
			out_stamp_q       <= r_stamp;
			aggregate_q       <= r_value;
			aggregate_valid_q <= r_valid;
		end else if (state_q == ST_WAIT && out_free) begin
			out_stamp_q       <= stamp_q;
			aggregate_q       <= neg_q ? -quo : quo;
			aggregate_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && r_div) begin
						state_q <= ST_DIV;
						step_q  <= STEP_W'(SUM_W);
					end
				end
				ST_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == STEP_W'(1)) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if ((pop && !r_div) || (state_q == ST_WAIT && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_stamp       = out_stamp_q;
	assign aggregate       = aggregate_q;
	assign aggregate_valid = aggregate_valid_q;
endmodule
`default_nettype wire

[hdl/multi_source_min_max_avg_aggregator_top.sv]
// a min or max result goes through the group queue and the output register, an average
// also through the SUM_W-bit divider (SUM_W = 32 + clog2(MAX_SOURCES+1), 37 at 16)
// throughput: one input word per cycle while in_stall is low; the back part takes no new
// group while its bit-serial divider runs; a 2-entry group queue parts front and back
// reset: asynchronous, clears the group state, the queue and out_valid; method = average,
// required_count = 1
`default_nettype none
module multi_source_min_max_avg_aggregator_top #(
	parameter int unsigned MAX_SOURCES = msagg_pkg::MAX_SOURCES_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [msagg_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [msagg_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [msagg_pkg::STAMP_W-1:0]          stamp,
	input  wire logic signed [msagg_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic                                   usable,
	input  wire logic                                   last_source,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [msagg_pkg::STAMP_W-1:0]               out_stamp,
	output logic signed [msagg_pkg::SAMPLE_W-1:0]       aggregate,
	output logic                                        aggregate_valid
);
	import msagg_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_SOURCES + 1);
	localparam int unsigned SUM_W = SAMPLE_W + CNT_W;
	localparam int unsigned REC_W = STAMP_W + SUM_W + CNT_W + SAMPLE_W + 2;

	cfg_t             cfg_q;
	logic             fifo_full, fifo_empty, push, pop;
	logic [REC_W-1:0] rec_in, rec_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.method         <= RED_AVG;
			cfg_q.required_count <= REQ_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_METHOD:   cfg_q.method         <= cfg_data[METHOD_W-1:0];
				CFG_REQUIRED: cfg_q.required_count <= cfg_data[REQ_W-1:0];
				default:      cfg_q                <= cfg_q;
			endcase
		end
	end

	msagg_front #(
		.MAX_SOURCES(MAX_SOURCES),
		.CNT_W(CNT_W),
		.SUM_W(SUM_W),
		.REC_W(REC_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stamp(stamp),
		.sample(sample),
		.usable(usable),
		.last_source(last_source),
		.fifo_full(fifo_full),
		.push(push),
		.rec(rec_in)
	);

	msagg_fifo #(
		.WIDTH(REC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(rec_in),
		.pop(pop),
		.rdata(rec_out),
		.full(fifo_full),
		.empty(fifo_empty)
	);

	msagg_back #(
		.CNT_W(CNT_W),
		.SUM_W(SUM_W),
		.REC_W(REC_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.rec(rec_out),
		.fifo_empty(fifo_empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_stamp(out_stamp),
		.aggregate(aggregate),
		.aggregate_valid(aggregate_valid)
	);
endmodule
`default_nettype wire

[hdl/msagg_checker.sv]
`default_nettype none
module msagg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] out_stamp,
	input wire logic [31:0] aggregate,
	input wire logic        aggregate_valid
);
	// a stalled result word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_stamp) && $stable(aggregate))
		else $error("stalled result word changed");

	// a result that missed quorum carries zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !aggregate_valid |-> aggregate == 32'd0)
		else $error("invalid result with nonzero aggregate");

	// nothing is shown right out of reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result shown right after reset");

	// a stalled result word keeps its quorum flag
	a_flag_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(aggregate_valid))
		else $error("quorum flag changed while stalled");
endmodule

bind multi_source_min_max_avg_aggregator_top msagg_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_stamp(out_stamp),
	.aggregate(aggregate),
	.aggregate_valid(aggregate_valid)
);
`default_nettype wire

[tb/multi_source_min_max_avg_aggregator_top_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module multi_source_min_max_avg_aggregator_top_tb;
	import msagg_pkg::*;

	localparam int unsigned MAX_SRC = MAX_SOURCES_DEF;
	localparam logic [METHOD_W-1:0] RED_SPARE = 2'd3;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int PHASE_WORDS = 180;
	localparam int PHASES = 8;

	typedef struct {
		logic [STAMP_W-1:0]         stamp;
		logic signed [SAMPLE_W-1:0] value;
		logic                       ok;
	} agg_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0]     cfg_index = CFG_METHOD;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [STAMP_W-1:0]         stamp = '0;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       usable = 1'b0;
	logic                       last_source = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [STAMP_W-1:0]         out_stamp;
	logic signed [SAMPLE_W-1:0] aggregate;
	logic                       aggregate_valid;

	// mirror of the block: settings and the open group
	cfg_t                       model_cfg = '{method: RED_AVG, required_count: REQ_RESET};
	longint                     grp_sum = 0;
	logic signed [SAMPLE_W-1:0] grp_min = '0;
	logic signed [SAMPLE_W-1:0] grp_max = '0;
	int unsigned                grp_count = 0;
	agg_t                       expected_aggs[$];

	int  fail_count = 0;
	int  cycle_count = 0;
	int  hold_left = 0;
	int  stall_left = 0;
	bit  steady = 1'b0;

	multi_source_min_max_avg_aggregator_top #(
		.MAX_SOURCES(MAX_SRC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stamp(stamp),
		.sample(sample),
		.usable(usable),
		.last_source(last_source),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_stamp(out_stamp),
		.aggregate(aggregate),
		.aggregate_valid(aggregate_valid)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom;
		if (r < 80)
			return 32'sd1000 - SAMPLE_W'($urandom_range(0, 2000));
		if (r < 90)
			return 32'h7FFF_FFFF;
		return 32'h8000_0000;
	endfunction

	function automatic logic [STAMP_W-1:0] pick_stamp();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	// receiver: random stalls, a long hold on request that holds even in steady stretches, else none there
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (steady) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	task automatic absorb_word(input logic [STAMP_W-1:0] st, input logic signed [SAMPLE_W-1:0] smp,
			input logic use_it, input logic last_it);
		agg_t        res;
		int unsigned need;
		longint      quot;
		if (use_it && grp_count < MAX_SRC) begin
			if (grp_count == 0) begin
				grp_min = smp;
				grp_max = smp;
			end else begin
				if (smp < grp_min)
					grp_min = smp;
				if (smp > grp_max)
					grp_max = smp;
			end
			grp_sum += smp;
			grp_count++;
		end
		if (last_it) begin
			need = (model_cfg.required_count == 0) ? 1 : model_cfg.required_count;
			res.stamp = st;
			res.ok = (grp_count != 0) && (grp_count >= need);
			res.value = '0;
			if (res.ok) begin
				case (model_cfg.method)
					RED_MIN: res.value = grp_min;
					RED_MAX: res.value = grp_max;
					default: begin
						// signed divide truncates toward zero
						quot = grp_sum / longint'(grp_count);
						res.value = quot[SAMPLE_W-1:0];
					end
				endcase
			end
			expected_aggs.push_back(res);
			grp_sum = 0;
			grp_min = '0;
			grp_max = '0;
			grp_count = 0;
		end
	endtask

	// sampled mid-cycle: whatever is seen here is taken at the next rising edge
	always @(negedge clk) begin
		agg_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_METHOD: model_cfg.method = cfg_data[METHOD_W-1:0];
					CFG_REQUIRED: model_cfg.required_count = cfg_data[REQ_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				absorb_word(stamp, sample, usable, last_source);
			if (out_valid && !out_stall) begin
				if (expected_aggs.size() == 0) begin
					$error("unexpected result word, out_stamp %h", out_stamp);
					fail_count++;
				end else begin
					want = expected_aggs.pop_front();
					if (out_stamp !== want.stamp) begin
						$error("out_stamp: expected %h, got %h", want.stamp, out_stamp);
						fail_count++;
					end
					if (aggregate !== want.value) begin
						$error("aggregate: expected %h, got %h", want.value, aggregate);
						fail_count++;
					end
					if (aggregate_valid !== want.ok) begin
						$error("aggregate_valid: expected %b, got %b", want.ok,
							aggregate_valid);
						fail_count++;
					end
				end
			end
		end
	end

	task automatic send_word(input logic [STAMP_W-1:0] st, input logic signed [SAMPLE_W-1:0] smp,
			input logic use_it, input logic last_it);
		logic took;
		int   gap;
		in_valid <= 1'b1;
		stamp <= st;
		sample <= smp;
		usable <= use_it;
		last_source <= last_it;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// all results in, then enough cycles for a divide still in flight
	task automatic wait_idle();
		if (in_valid)
			in_valid <= 1'b0;
		while (expected_aggs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_word(32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
		send_word(32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
		// sum of -1 over two rounds to zero
		send_word(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
		send_word(32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
	endtask

	task automatic test_methods();
		wait_idle();
		write_reg(CFG_METHOD, CFG_DATA_W'(RED_MIN));
		send_word(32'h0000_1000, 32'hFFFD_0000, 1'b1, 1'b0);
		send_word(32'h0000_1000, 32'h8000_0000, 1'b0, 1'b1);
		wait_idle();
		write_reg(CFG_METHOD, CFG_DATA_W'(RED_MAX));
		send_word(32'h0000_1001, 32'h0005_0000, 1'b1, 1'b0);
		send_word(32'h0000_1001, 32'h7FFF_FFFF, 1'b0, 1'b1);
		// spare code falls back to average, -5 / 2 gives -2
		wait_idle();
		write_reg(CFG_METHOD, CFG_DATA_W'(RED_SPARE));
		send_word(32'h0000_1002, 32'hFFFF_FFFD, 1'b1, 1'b0);
		send_word(32'h0000_1002, 32'hFFFF_FFFE, 1'b1, 1'b1);
	endtask

	task automatic test_method_switch_in_group();
		wait_idle();
		write_reg(CFG_METHOD, CFG_DATA_W'(RED_MIN));
		send_word(32'h0000_2000, 32'h000A_0000, 1'b1, 1'b0);
		send_word(32'h0000_2000, 32'hFFF9_0000, 1'b1, 1'b0);
		wait_idle();
		write_reg(CFG_METHOD, CFG_DATA_W'(RED_MAX));
		send_word(32'h0000_2000, 32'h0001_0000, 1'b1, 1'b1);
	endtask

	task automatic test_quorum_edges();
		wait_idle();
		write_reg(CFG_METHOD, CFG_DATA_W'(RED_AVG));
		write_reg(CFG_REQUIRED, 5'd0);
		send_word(32'h0000_3000, 32'h1234_5678, 1'b0, 1'b1);
		send_word(32'h0000_3001, 32'h0002_0000, 1'b1, 1'b1);
		// quorum beyond the source limit is never met
		wait_idle();
		write_reg(CFG_REQUIRED, 5'd17);
		send_word(32'h0000_3002, 32'h0003_0000, 1'b1, 1'b0);
		send_word(32'h0000_3002, 32'h0004_0000, 1'b1, 1'b1);
	endtask

	task automatic test_source_overflow();
		int k;
		wait_idle();
		write_reg(CFG_REQUIRED, 5'(MAX_SRC));
		for (k = 0; k < MAX_SRC; k++)
			send_word(32'h0000_4000, 32'h7FFF_FFFF, 1'b1, 1'b0);
		// one source too many: must be dropped from sum and extremes
		send_word(32'h0000_4000, 32'h8000_0000, 1'b1, 1'b1);
	endtask

	task automatic test_backpressure();
		int k;
		wait_idle();
		write_reg(CFG_METHOD, CFG_DATA_W'(RED_AVG));
		write_reg(CFG_REQUIRED, 5'd1);
		steady = 1'b1;
		hold_left = 300;
		for (k = 0; k < 24; k++)
			send_word(pick_stamp(), pick_sample(), 1'b1, 1'b1);
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		logic [METHOD_W-1:0] methods [PHASES] = '{RED_AVG, RED_MIN, RED_MAX,
			RED_SPARE, RED_AVG, RED_MIN, RED_MAX, RED_AVG};
		int                  quorums [PHASES] = '{1, 16, 0, 31, 17, 4, 2, 8};
		logic [METHOD_W-1:0] m;
		int                  q;
		int                  ph;
		int                  k;
		int                  sent;
		int                  size;
		int                  mode;
		int                  r;
		logic [STAMP_W-1:0]  st;
		logic                use_it;
		for (ph = 0; ph < PHASES; ph++) begin
			m = methods[ph];
			q = quorums[ph];
			if (ph == PHASES - 1) begin
				m = METHOD_W'($urandom_range(0, 3));
				q = $urandom_range(0, 31);
			end
			wait_idle();
			write_reg(CFG_METHOD, CFG_DATA_W'(m));
			write_reg(CFG_REQUIRED, CFG_DATA_W'(q));
			steady = (ph == 2 || ph == 5);
			sent = 0;
			while (sent < PHASE_WORDS) begin
				r = $urandom_range(0, 9);
				if (r < 7)
					size = $urandom_range(1, 8);
				else if (r < 9)
					size = $urandom_range(9, MAX_SRC);
				else
					size = $urandom_range(MAX_SRC + 1, MAX_SRC + 6);
				mode = $urandom_range(0, 2);
				st = pick_stamp();
				for (k = 0; k < size; k++) begin
					case (mode)
						0: use_it = 1'b1;
						1: use_it = ($urandom_range(0, 4) != 0);
						default: use_it = ($urandom_range(0, 9) < 3);
					endcase
					send_word(st, pick_sample(), use_it, k == size - 1);
				end
				sent += size;
			end
			steady = 1'b0;
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_methods();
		test_method_switch_in_group();
		test_quorum_edges();
		test_source_overflow();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
